// ===== src/lpra_pkg.sv =====
// Package for the lagged-product range ambiguity core.
// Holds the shared sample and pair types and the fixed widths; no dependencies.
`default_nettype none
package lpra_pkg;
    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 48;
    localparam int LAG_W       = 6;
    localparam int CNT_W       = 16;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       ok;
    } sample_t;

    typedef struct packed {
        sample_t a;
        sample_t b;
    } pair_t;
endpackage
`default_nettype wire

// ===== src/lpra_if.sv =====
// Channel interfaces of the lagged-product range ambiguity core.
// Depends on lpra_pkg for the field widths.
`default_nettype none
interface lpra_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lpra_pkg::LAG_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

interface lpra_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lpra_pkg::SAMPLE_W-1:0] first_re;
    logic signed [lpra_pkg::SAMPLE_W-1:0] first_im;
    logic                                first_valid;
    logic signed [lpra_pkg::SAMPLE_W-1:0] second_re;
    logic signed [lpra_pkg::SAMPLE_W-1:0] second_im;
    logic                                second_valid;
    logic                                final_sample;
    modport source (output valid, first_re, first_im, first_valid, second_re, second_im,
                    second_valid, final_sample, input ready);
    modport sink (input valid, first_re, first_im, first_valid, second_re, second_im,
                  second_valid, final_sample, output ready);
endinterface

interface lpra_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lpra_pkg::ACC_W-1:0] product_re;
    logic signed [lpra_pkg::ACC_W-1:0] product_im;
    logic                              hit;
    logic                              run_end;
    modport source (output valid, product_re, product_im, hit, run_end, input ready);
    modport sink (input valid, product_re, product_im, hit, run_end, output ready);
endinterface
`default_nettype wire

// ===== src/lagged_product_range_ambiguity_core.sv =====
// Top level of the lagged-product range ambiguity core.
// Depends on lpra_pkg, the channel interfaces, lpra_ram and lpra_mac.
`default_nettype none
// The core takes one request of paired complex samples at a time, delays channel one by
// the lag register through a 64-entry sample memory, and returns one result per aligned
// position: the hit flag and the interpolated mean product scaled by (2N) cubed. A result
// for a position leaves once the following position has arrived; the final request also
// yields the last position and then lag zero-flag tail results; a vector no longer than
// the lag yields one such result per input instead. The last is marked run_end. An
// ordinary request writes the sample and reads the delayed one, then forms the aligned
// pair and runs the shared multiply-accumulate unit, which handles one interpolation
// point per cycle through three pipeline stages. The final request runs the unit once
// more for the last position and then emits the tail results. The results side has an
// output register, so a new request is taken while the last result still waits.
// The lag register may be written only while the core is idle; values above MAX_LAG
// act as MAX_LAG. The delay memory needs no clearing after reset.
module lagged_product_range_ambiguity_core #(
    parameter int INTERP_POINTS = 4,
    parameter int MAX_LAG       = 62
) (
    input wire logic     clk,
    input wire logic     rst_n,
    lpra_cfg_if.sink     cfg,
    lpra_in_if.sink      samples,
    lpra_out_if.source   results
);
    localparam int AW = lpra_pkg::ADDR_W;
    localparam int LW = lpra_pkg::LAG_W;
    localparam int NW = lpra_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_MAC_MID, S_EMIT_MID, S_WRAP, S_MAC_LAST, S_EMIT_LAST, S_TAIL
    } state_t;

    state_t state_reg;
    logic [LW-1:0] lag_reg, lag_eff, l_reg, tail_reg;
    logic [NW-1:0] count_reg;
    logic [AW-1:0] wp_reg;
    logic aligned_reg, k1_reg, k2_reg, fin_reg, hit_reg;
    lpra_pkg::pair_t hist0_reg, hist1_reg, now_c, nx_c, mac_next;
    lpra_pkg::sample_t s1_reg, s1_in, s2_reg, rdata;
    logic accept, out_free, out_load, ram_re, mac_start, mac_done;
    logic [AW-1:0] raddr;
    logic signed [lpra_pkg::ACC_W-1:0] acc_re, acc_im;
    logic out_valid_reg, out_hit_reg, out_end_reg;
    logic signed [lpra_pkg::ACC_W-1:0] out_re_reg, out_im_reg;

    // Always writable: the user must send writes only while the core is idle.
    assign cfg.ready = 1'b1;
    assign lag_eff   = (lag_reg > LW'(MAX_LAG)) ? LW'(MAX_LAG) : lag_reg;

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign out_load      = out_free && (state_reg inside {S_EMIT_MID, S_EMIT_LAST, S_TAIL});

    assign s1_in = '{re: samples.first_re, im: samples.first_im, ok: samples.first_valid};

    // Reading at the write address with zero lag would race the write, so the new
    // sample is forwarded instead.
    assign now_c.a = (l_reg == '0) ? s1_reg : rdata;
    assign now_c.b = s2_reg;
    // Past the last input, channel two reads as zero; channel one still has the
    // stored sample when the lag is nonzero.
    assign nx_c.a  = (l_reg == '0) ? lpra_pkg::sample_t'('0) : rdata;
    assign nx_c.b  = '0;

    assign ram_re = accept || (state_reg == S_FETCH);
    assign raddr  = (state_reg == S_FETCH) ? wp_reg - AW'(l_reg) + AW'(1)
                                           : wp_reg - AW'(lag_eff);

    assign mac_start = ((state_reg == S_FETCH) && aligned_reg && k1_reg)
                    || ((state_reg == S_WRAP) && fin_reg && aligned_reg);
    assign mac_next  = (state_reg == S_FETCH) ? now_c : nx_c;

    lpra_ram #(
        .WIDTH ($bits(lpra_pkg::sample_t)),
        .DEPTH (lpra_pkg::STORE_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (s1_in),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    lpra_mac #(
        .INTERP_POINTS (INTERP_POINTS)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mac_start),
        .prev_in      (hist0_reg),
        .cur_in       (hist1_reg),
        .next_in      (mac_next),
        .have_prev_in ((state_reg == S_FETCH) ? k2_reg : k1_reg),
        .done         (mac_done),
        .acc_re       (acc_re),
        .acc_im       (acc_im)
    );

    // Request payload; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_in;
            s2_reg <= '{re: samples.second_re, im: samples.second_im, ok: samples.second_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lag_reg       <= '0;
            l_reg         <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            aligned_reg   <= 1'b0;
            k1_reg        <= 1'b0;
            k2_reg        <= 1'b0;
            fin_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_end_reg   <= 1'b0;
            out_re_reg    <= '0;
            out_im_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                lag_reg <= cfg.data;
            end
            // A new result loads the output register; otherwise a taken one leaves it.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mac_start)
            begin
                hit_reg <= hist1_reg.a.ok && hist1_reg.b.ok;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        l_reg       <= lag_eff;
                        fin_reg     <= samples.final_sample;
                        aligned_reg <= count_reg >= NW'(lag_eff);
                        k1_reg      <= count_reg > NW'(lag_eff);
                        k2_reg      <= {1'b0, count_reg} > ((NW + 1)'(lag_eff) + (NW + 1)'(1));
                        state_reg   <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    if (aligned_reg)
                    begin
                        hist0_reg <= hist1_reg;
                        hist1_reg <= now_c;
                    end
                    state_reg <= (aligned_reg && k1_reg) ? S_MAC_MID : S_WRAP;
                end
                S_MAC_MID:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_EMIT_MID;
                    end
                end
                S_EMIT_MID:
                begin
                    if (out_free)
                    begin
                        out_hit_reg   <= hit_reg;
                        out_end_reg   <= 1'b0;
                        out_re_reg    <= hit_reg ? acc_re : '0;
                        out_im_reg    <= hit_reg ? acc_im : '0;
                        state_reg     <= S_WRAP;
                    end
                end
                S_WRAP:
                begin
                    if (!fin_reg)
                    begin
                        count_reg <= (count_reg == '1) ? count_reg : count_reg + NW'(1);
                        wp_reg    <= wp_reg + AW'(1);
                        state_reg <= S_IDLE;
                    end
                    else if (aligned_reg)
                    begin
                        state_reg <= S_MAC_LAST;
                    end
                    else
                    begin
                        // Vector no longer than the lag: one flagless result per input.
                        tail_reg  <= LW'(count_reg) + LW'(1);
                        state_reg <= S_TAIL;
                    end
                end
                S_MAC_LAST:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_EMIT_LAST;
                    end
                end
                S_EMIT_LAST:
                begin
                    if (out_free)
                    begin
                        out_hit_reg   <= hit_reg;
                        out_end_reg   <= (l_reg == '0);
                        out_re_reg    <= hit_reg ? acc_re : '0;
                        out_im_reg    <= hit_reg ? acc_im : '0;
                        tail_reg      <= l_reg;
                        if (l_reg == '0)
                        begin
                            count_reg <= '0;
                            wp_reg    <= '0;
                            hist0_reg <= '0;
                            hist1_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_TAIL;
                        end
                    end
                end
                S_TAIL:
                begin
                    if (out_free)
                    begin
                        out_hit_reg   <= 1'b0;
                        out_end_reg   <= (tail_reg == LW'(1));
                        out_re_reg    <= '0;
                        out_im_reg    <= '0;
                        tail_reg      <= tail_reg - LW'(1);
                        if (tail_reg == LW'(1))
                        begin
                            count_reg <= '0;
                            wp_reg    <= '0;
                            hist0_reg <= '0;
                            hist1_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.product_re = out_re_reg;
    assign results.product_im = out_im_reg;
    assign results.hit        = out_hit_reg;
    assign results.run_end    = out_end_reg;

    // A result without a hit always carries a zero product.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.hit |-> results.product_re == '0 && results.product_im == '0)
        else $error("nonzero product on a result without hit");

    // Tail results are only produced for the final request of a vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAIL |-> fin_reg && tail_reg != '0)
        else $error("tail results outside a final request");

    // The effective lag never exceeds the configured maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> l_reg <= LW'(MAX_LAG))
        else $error("lag above MAX_LAG in use");

    // The multiply-accumulate unit is started only while no position is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_start |-> !(state_reg == S_MAC_MID || state_reg == S_MAC_LAST))
        else $error("accumulator restarted while busy");
endmodule
`default_nettype wire

// ===== src/lpra_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module lpra_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/lpra_mac.sv =====
// Shared multiply-accumulate unit: sums conj(ch1)*ch2 over the interpolated points
// of one position, one point per cycle through a three-stage pipeline. Uses lpra_pkg.
`default_nettype none
module lpra_mac #(
    parameter int INTERP_POINTS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire lpra_pkg::pair_t                   prev_in,
    input  wire lpra_pkg::pair_t                   cur_in,
    input  wire lpra_pkg::pair_t                   next_in,
    input  wire logic                              have_prev_in,
    output logic                                   done,
    output logic signed [lpra_pkg::ACC_W-1:0]      acc_re,
    output logic signed [lpra_pkg::ACC_W-1:0]      acc_im
);
    localparam int D   = 2 * INTERP_POINTS;
    localparam int CW  = $clog2(D + 1);
    localparam int IW  = $clog2(INTERP_POINTS + 1);
    localparam int U_W = lpra_pkg::SAMPLE_W + $clog2(D);
    localparam int P_W = 2 * U_W;
    localparam int A_W = lpra_pkg::ACC_W;

    lpra_pkg::pair_t prev_reg, cur_reg, next_reg, oth;
    logic have_prev_reg;
    logic run_reg, seg_reg, va_reg, la_reg, ea_reg, vb_reg, lb_reg, eb_reg, done_reg;
    logic [IW-1:0] i_reg;
    logic [CW-1:0] wc, wo;
    logic signed [U_W-1:0] wcs, wos;
    logic signed [U_W-1:0] ur1_reg, ui1_reg, ur2_reg, ui2_reg;
    logic signed [P_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [A_W-1:0] acc_re_reg, acc_im_reg;
    logic last_pt, seg_end;

    function automatic logic signed [U_W-1:0] mix(
        input logic signed [lpra_pkg::SAMPLE_W-1:0] x,
        input logic signed [lpra_pkg::SAMPLE_W-1:0] o,
        input logic signed [U_W-1:0]                wx,
        input logic signed [U_W-1:0]                wy
    );
        logic signed [U_W-1:0] xe, oe;
        xe = U_W'(x);
        oe = U_W'(o);
        return xe * wx + oe * wy;
    endfunction

    assign oth     = seg_reg ? next_reg : prev_reg;
    assign wc      = CW'(D) - CW'(i_reg);
    assign wo      = CW'(i_reg);
    assign wcs     = $signed(U_W'(wc));
    assign wos     = $signed(U_W'(wo));
    assign seg_end = (i_reg == IW'(INTERP_POINTS - 1));
    assign last_pt = seg_reg && seg_end;

    // Operands and pipeline payload.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prev_reg      <= prev_in;
            cur_reg       <= cur_in;
            next_reg      <= next_in;
            have_prev_reg <= have_prev_in;
        end
        ur1_reg  <= mix(cur_reg.a.re, oth.a.re, wcs, wos);
        ui1_reg  <= mix(cur_reg.a.im, oth.a.im, wcs, wos);
        ur2_reg  <= mix(cur_reg.b.re, oth.b.re, wcs, wos);
        ui2_reg  <= mix(cur_reg.b.im, oth.b.im, wcs, wos);
        p_rr_reg <= P_W'(ur1_reg) * P_W'(ur2_reg);
        p_ii_reg <= P_W'(ui1_reg) * P_W'(ui2_reg);
        p_ri_reg <= P_W'(ur1_reg) * P_W'(ui2_reg);
        p_ir_reg <= P_W'(ui1_reg) * P_W'(ur2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            seg_reg    <= 1'b0;
            i_reg      <= '0;
            va_reg     <= 1'b0;
            la_reg     <= 1'b0;
            ea_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            lb_reg     <= 1'b0;
            eb_reg     <= 1'b0;
            done_reg   <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            va_reg   <= run_reg;
            la_reg   <= last_pt;
            ea_reg   <= seg_reg || have_prev_reg;
            vb_reg   <= va_reg;
            lb_reg   <= la_reg;
            eb_reg   <= ea_reg;
            done_reg <= vb_reg && lb_reg;
            if (start)
            begin
                run_reg    <= 1'b1;
                seg_reg    <= 1'b0;
                i_reg      <= '0;
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end
            else
            begin
                if (run_reg)
                begin
                    i_reg <= seg_end ? '0 : i_reg + IW'(1);
                    if (seg_end)
                    begin
                        seg_reg <= 1'b1;
                    end
                    if (last_pt)
                    begin
                        run_reg <= 1'b0;
                    end
                end
                if (vb_reg && eb_reg)
                begin
                    acc_re_reg <= acc_re_reg + A_W'(p_rr_reg) + A_W'(p_ii_reg);
                    acc_im_reg <= acc_im_reg + A_W'(p_ri_reg) - A_W'(p_ir_reg);
                end
            end
        end
    end

    assign done   = done_reg;
    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
endmodule
`default_nettype wire

// ===== bench/lpra_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class for the lagged-product range ambiguity bench.
// Depends on lpra_pkg for widths; holds the expected-result queue and the checks.
package lpra_tb_pkg;

    typedef struct {
        logic signed [lpra_pkg::ACC_W-1:0] pr;
        logic signed [lpra_pkg::ACC_W-1:0] pi;
        logic                              hit;
        logic                              run_end;
    } product_t;

    class product_scoreboard;
        product_t pending[$];
        int       errors = 0;

        function void note(product_t p);
            pending.push_back(p);
        endfunction

        function void check(product_t got);
            product_t want;
            if (pending.size() == 0)
            begin
                $display("%t: unexpected result re=%0d im=%0d hit=%0b end=%0b",
                         $realtime, got.pr, got.pi, got.hit, got.run_end);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.pr !== want.pr)
            begin
                $display("%t: product_re expected %0d actual %0d", $realtime, want.pr, got.pr);
                errors++;
            end
            if (got.pi !== want.pi)
            begin
                $display("%t: product_im expected %0d actual %0d", $realtime, want.pi, got.pi);
                errors++;
            end
            if (got.hit !== want.hit)
            begin
                $display("%t: hit expected %0b actual %0b", $realtime, want.hit, got.hit);
                errors++;
            end
            if (got.run_end !== want.run_end)
            begin
                $display("%t: run_end expected %0b actual %0b", $realtime, want.run_end,
                         got.run_end);
                errors++;
            end
        endfunction
    endclass
endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top-level bench for lagged_product_range_ambiguity_core.
// Depends on lpra_pkg, the channel interfaces and lpra_tb_pkg.
module tb;

    localparam int NPTS = 4;
    localparam int LAG_LIMIT = 62;
    localparam int ITEMS = 470;

    logic clk;
    logic rst_n;

    lpra_cfg_if cfg ();
    lpra_in_if  samples ();
    lpra_out_if results ();

    lagged_product_range_ambiguity_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg.sink),
        .samples (samples),
        .results (results)
    );

    // Predictor state: the delayed channel-one samples, the two last aligned pairs,
    // the position count and the write pointer, mirroring the core.
    lpra_tb_pkg::product_scoreboard board;
    lpra_pkg::sample_t              delay_mem[lpra_pkg::STORE_DEPTH];
    lpra_pkg::pair_t                hist0, hist1;
    int unsigned                    seen;
    int unsigned                    wr_ptr;
    int unsigned                    lag_now;
    bit                             calm;          // no idling at all while set

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Sum one interpolated segment between pair cur and pair oth into sr/si.
    function automatic void add_segment(lpra_pkg::pair_t cur, lpra_pkg::pair_t oth,
                                        inout longint sr, inout longint si);
        longint d, r1, i1, r2, i2;
        d = 2 * NPTS;
        for (int i = 0; i < NPTS; i++)
        begin
            r1 = longint'(cur.a.re) * (d - i) + longint'(oth.a.re) * i;
            i1 = longint'(cur.a.im) * (d - i) + longint'(oth.a.im) * i;
            r2 = longint'(cur.b.re) * (d - i) + longint'(oth.b.re) * i;
            i2 = longint'(cur.b.im) * (d - i) + longint'(oth.b.im) * i;
            sr += r1 * r2 + i1 * i2;
            si += r1 * i2 - i1 * r2;
        end
    endfunction

    function automatic lpra_tb_pkg::product_t position_product(lpra_pkg::pair_t prev,
                                                               bit has_prev,
                                                               lpra_pkg::pair_t cur,
                                                               lpra_pkg::pair_t nxt);
        lpra_tb_pkg::product_t p;
        longint                sr, si;
        sr = 0;
        si = 0;
        p.hit = cur.a.ok & cur.b.ok;
        if (p.hit)
        begin
            if (has_prev)
                add_segment(cur, prev, sr, si);
            add_segment(cur, nxt, sr, si);
        end
        p.pr = sr[lpra_pkg::ACC_W-1:0];
        p.pi = si[lpra_pkg::ACC_W-1:0];
        p.run_end = 0;
        return p;
    endfunction

    // Works out every result that one accepted request causes and queues it.
    task automatic predict_products(lpra_pkg::sample_t s1, lpra_pkg::sample_t s2, bit fin);
        int unsigned           l, k, tail;
        bit                    aligned;
        lpra_pkg::pair_t       now, nx;
        lpra_tb_pkg::product_t z;
        lpra_tb_pkg::product_t outs[$];
        l = lag_now > LAG_LIMIT ? LAG_LIMIT : lag_now;
        aligned = seen >= l;
        k = aligned ? seen - l : 0;
        delay_mem[wr_ptr] = s1;
        if (aligned)
        begin
            now.a = delay_mem[(wr_ptr - l) % lpra_pkg::STORE_DEPTH];
            now.b = s2;
            if (k >= 1)
                outs.push_back(position_product(hist0, k >= 2, hist1, now));
            hist0 = hist1;
            hist1 = now;
        end
        if (!fin)
        begin
            if (seen < 16'hFFFF)
                seen++;
            wr_ptr = (wr_ptr + 1) % lpra_pkg::STORE_DEPTH;
        end
        else
        begin
            if (aligned)
            begin
                nx = '0;
                if (l > 0)
                    nx.a = delay_mem[(wr_ptr - l + 1) % lpra_pkg::STORE_DEPTH];
                outs.push_back(position_product(hist0, k >= 1, hist1, nx));
                tail = l;
            end
            else
                tail = seen + 1;
            z = '{0, 0, 0, 0};
            for (int t = 0; t < tail; t++)
                outs.push_back(z);
            outs[outs.size() - 1].run_end = 1;
            seen = 0;
            wr_ptr = 0;
            hist0 = '0;
            hist1 = '0;
        end
        foreach (outs[i])
            board.note(outs[i]);
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 22);
    endfunction

    // Drives one sample request and waits for it to be taken. Valid stays up after
    // the request is taken; the core is busy then, and the next caller either drives
    // a new request or drops valid.
    task automatic send_sample(lpra_pkg::sample_t s1, lpra_pkg::sample_t s2, bit fin);
        while (idle_now())
        begin
            samples.valid <= 0;
            @(negedge clk);
        end
        samples.valid        <= 1;
        samples.first_re     <= s1.re;
        samples.first_im     <= s1.im;
        samples.first_valid  <= s1.ok;
        samples.second_re    <= s2.re;
        samples.second_im    <= s2.im;
        samples.second_valid <= s2.ok;
        samples.final_sample <= fin;
        do
            @(posedge clk);
        while (!samples.ready);
        predict_products(s1, s2, fin);
        @(negedge clk);
    endtask

    // Writes the lag once the core has drained and the tail results have been taken.
    task automatic write_lag(int unsigned value);
        samples.valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        cfg.valid <= 1;
        cfg.data  <= value[lpra_pkg::LAG_W-1:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        lag_now = value;
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    function automatic lpra_pkg::sample_t random_sample(bit edgy);
        lpra_pkg::sample_t s;
        if (edgy)
        begin
            s.re = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            s.im = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        else
        begin
            s.re = 16'($urandom);
            s.im = 16'($urandom);
        end
        s.ok = $urandom_range(99) < 80;
        return s;
    endfunction

    // Sends one vector of the given length with random content.
    task automatic send_vector(int len);
        bit edgy;
        edgy = $urandom_range(9) == 0;
        for (int i = 0; i < len; i++)
            send_sample(random_sample(edgy), random_sample(edgy), i == len - 1);
    endtask

    // Results side: takes a result at each rising edge where valid and ready meet.
    initial
    begin
        lpra_tb_pkg::product_t got;
        results.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            results.ready <= !idle_now();
            @(posedge clk);
            if (results.valid && results.ready)
            begin
                got.pr = results.product_re;
                got.pi = results.product_im;
                got.hit = results.hit;
                got.run_end = results.run_end;
                board.check(got);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("[lagged_product_range_ambiguity_core] ERROR");
        $finish;
    end

    initial
    begin
        lpra_pkg::sample_t a, b;
        int                sent;
        board = new();
        seen = 0;
        wr_ptr = 0;
        lag_now = 0;
        hist0 = '0;
        hist1 = '0;
        calm = 0;
        rst_n = 0;
        cfg.valid = 0;
        cfg.data = '0;
        samples.valid = 0;
        samples.first_re = '0;
        samples.first_im = '0;
        samples.first_valid = 0;
        samples.second_re = '0;
        samples.second_im = '0;
        samples.second_valid = 0;
        samples.final_sample = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed part: lag zero, a one-sample vector (first and last position at
        // once), extreme values with both flags, and a vector no longer than the lag.
        write_lag(0);
        a = '{16'sh7FFF, 16'sh8000, 1};
        b = '{16'sh8000, 16'sh7FFF, 1};
        send_sample(a, b, 1);
        send_sample(a, b, 0);
        send_sample('{16'sh8000, 16'sh8000, 1}, '{16'sh8000, 16'sh8000, 1}, 0);
        send_sample('{16'sh7FFF, 16'sh7FFF, 0}, '{16'sh7FFF, 16'sh7FFF, 1}, 0);
        send_sample('{16'sh8000, 16'sh7FFF, 1}, '{16'sh0000, 16'sh0000, 0}, 1);
        write_lag(3);
        send_vector(2);
        send_vector(3);
        send_vector(7);
        write_lag(63);       // above the limit, acts as the limit
        send_vector(5);

        // Random part over several lag settings, a calm stretch in the middle.
        sent = 22;
        while (sent < ITEMS)
        begin
            case ($urandom_range(5))
                0: write_lag(0);
                1: write_lag(62);
                2: write_lag(63);
                default: write_lag($urandom_range(1, 8));
            endcase
            calm = (sent > 150 && sent < 250);
            for (int v = 0; v < 4 && sent < ITEMS; v++)
            begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 70)
                                               : $urandom_range(1, 12 + lag_now % 64);
                if (sent + len > ITEMS)
                    len = ITEMS - sent;
                send_vector(len);
                sent += len;
            end
        end
        calm = 0;
        samples.valid <= 0;

        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[lagged_product_range_ambiguity_core] OK");
        else
            $display("[lagged_product_range_ambiguity_core] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
src/lpra_pkg.sv
src/lpra_if.sv
src/lpra_ram.sv
src/lpra_mac.sv
src/lagged_product_range_ambiguity_core.sv
bench/lpra_tb_pkg.sv
bench/tb.sv
